// ----- rtl/fcr_pkg.sv -----
package fcr_pkg;

    localparam logic [7:0] HDR_BYTE0 = 8'h5A;
    localparam logic [7:0] HDR_BYTE1 = 8'hA5;
    localparam logic [7:0] CMD_TYPE  = 8'h82;

    localparam logic [7:0] ORD_MAIN_POWER = 8'h01;
    localparam logic [7:0] ORD_APP_START  = 8'h02;
    localparam logic [7:0] ORD_HANDSET    = 8'h33;
    localparam logic [7:0] ORD_FREQUENCY  = 8'h04;
    localparam logic [7:0] ORD_PRESSURE   = 8'h05;
    localparam logic [7:0] ORD_COUNT      = 8'h06;

    localparam logic [7:0] ARG_ONE  = 8'h01;
    localparam logic [7:0] ARG_ZERO = 8'h00;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CMD   = 2'd1;
    localparam logic [1:0] ERR_ORDER = 2'd2;

    localparam int          HEAD_KEEP  = 5;
    localparam logic [7:0]  HEAD_LIMIT = 8'd5;
    localparam logic [7:0]  PRESS_RST  = 8'd10;

    typedef enum logic [1:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_LEN,
        PH_BODY
    } t_phase;

    // frame event seen by the order decoder for the byte in flight
    typedef struct packed {
        logic       done;
        logic       decode;
        logic [7:0] cmd;
        logic [7:0] code;
        logic [7:0] hi;
        logic [7:0] lo;
    } t_frame_evt;

    typedef struct packed {
        logic        frame_done;
        logic [1:0]  error_code;
        logic        main_power;
        logic        app_start;
        logic        power_on;
        logic        stop_request;
        logic        clear_display;
        logic        menu_init;
        logic        refresh_request;
        logic [7:0]  pressure;
        logic [7:0]  frequency;
        logic [15:0] shock_count;
    } t_status;

endpackage

// ----- rtl/fcr_parser.sv -----
module fcr_parser #(
    parameter int MAX_FRAME_LEN = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    output fcr_pkg::t_frame_evt o_evt
);

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME_LEN);

    fcr_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_len, n_len;
    logic [7:0]      r_cnt, n_cnt;
    logic [7:0]      r_head [fcr_pkg::HEAD_KEEP];
    logic [7:0]      w_head [fcr_pkg::HEAD_KEEP];
    logic [7:0]      w_cnt_inc;
    logic            w_done;

    // payload head with the current byte merged in
    always_comb begin
        for (int i = 0; i < fcr_pkg::HEAD_KEEP; i++) begin
            if (r_phase == fcr_pkg::PH_BODY && r_cnt < fcr_pkg::HEAD_LIMIT
                    && r_cnt[2:0] == 3'(i)) begin
                w_head[i] = i_byte;
            end else begin
                w_head[i] = r_head[i];
            end
        end
        w_cnt_inc = (r_cnt == 8'hFF) ? r_cnt : r_cnt + 8'd1;
        w_done    = (r_phase == fcr_pkg::PH_BODY) && (w_cnt_inc >= r_len);
    end

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_cnt   = r_cnt;
        case (r_phase)
            fcr_pkg::PH_SYNC0: begin
                n_phase = (i_byte == fcr_pkg::HDR_BYTE0) ? fcr_pkg::PH_SYNC1
                                                         : fcr_pkg::PH_SYNC0;
            end
            fcr_pkg::PH_SYNC1: begin
                n_phase = (i_byte == fcr_pkg::HDR_BYTE1) ? fcr_pkg::PH_LEN
                                                         : fcr_pkg::PH_SYNC0;
            end
            fcr_pkg::PH_LEN: begin
                n_len   = (i_byte > MaxLen) ? MaxLen : i_byte;
                n_cnt   = 8'd0;
                n_phase = (i_byte == 8'd0) ? fcr_pkg::PH_SYNC0 : fcr_pkg::PH_BODY;
            end
            fcr_pkg::PH_BODY: begin
                if (w_done) begin
                    n_cnt   = 8'd0;
                    n_phase = fcr_pkg::PH_SYNC0;
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end
            default: begin
                n_phase = fcr_pkg::PH_SYNC0;
            end
        endcase
    end

    always_comb begin
        o_evt.done   = w_done;
        o_evt.decode = w_done && (r_len >= 8'd2);
        o_evt.cmd    = w_head[0];
        o_evt.code   = w_head[1];
        o_evt.hi     = w_head[3];
        o_evt.lo     = w_head[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fcr_pkg::PH_SYNC0;
            r_len   <= 8'd0;
            r_cnt   <= 8'd0;
            for (int i = 0; i < fcr_pkg::HEAD_KEEP; i++) begin
                r_head[i] <= 8'd0;
            end
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            for (int i = 0; i < fcr_pkg::HEAD_KEEP; i++) begin
                r_head[i] <= w_head[i];
            end
        end
    end

endmodule

// ----- rtl/fcr_decoder.sv -----
module fcr_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  fcr_pkg::t_frame_evt i_evt,
    input  logic [7:0]          i_idle_pressure,
    output fcr_pkg::t_status    o_status
);

    logic        r_main, n_main;
    logic        r_app, n_app;
    logic        r_pwr, n_pwr;
    logic [7:0]  r_press, n_press;
    logic [7:0]  r_freq, n_freq;
    logic [15:0] r_count, n_count;
    logic        w_stop, w_clear, w_menu, w_refresh;
    logic [1:0]  w_err;

    always_comb begin
        n_main    = r_main;
        n_app     = r_app;
        n_pwr     = r_pwr;
        n_press   = r_press;
        n_freq    = r_freq;
        n_count   = r_count;
        w_stop    = 1'b0;
        w_clear   = 1'b0;
        w_menu    = 1'b0;
        w_refresh = 1'b0;
        w_err     = fcr_pkg::ERR_NONE;
        if (i_evt.decode) begin
            if (i_evt.cmd != fcr_pkg::CMD_TYPE) begin
                w_err = fcr_pkg::ERR_CMD;
            end else begin
                case (i_evt.code)
                    fcr_pkg::ORD_MAIN_POWER: begin
                        if (i_evt.lo == fcr_pkg::ARG_ONE) begin
                            n_main = 1'b1;
                        end else begin
                            n_main  = 1'b0;
                            n_press = i_idle_pressure;
                            n_freq  = 8'd0;
                            n_count = 16'd0;
                            n_pwr   = 1'b0;
                            w_stop  = 1'b1;
                            w_clear = 1'b1;
                        end
                    end
                    fcr_pkg::ORD_APP_START: begin
                        if (i_evt.lo == fcr_pkg::ARG_ONE) begin
                            n_app = 1'b1;
                        end else begin
                            n_app     = 1'b0;
                            w_refresh = 1'b1;
                            w_stop    = 1'b1;
                        end
                    end
                    fcr_pkg::ORD_HANDSET: begin
                        if (i_evt.lo == fcr_pkg::ARG_ZERO) begin
                            n_pwr   = 1'b0;
                            w_stop  = 1'b1;
                            w_clear = 1'b1;
                        end else begin
                            n_pwr     = 1'b1;
                            w_refresh = 1'b1;
                            w_menu    = 1'b1;
                        end
                    end
                    fcr_pkg::ORD_FREQUENCY: begin
                        w_refresh = 1'b1;
                        n_freq    = i_evt.lo;
                    end
                    fcr_pkg::ORD_PRESSURE: begin
                        w_refresh = 1'b1;
                        n_press   = i_evt.lo;
                    end
                    fcr_pkg::ORD_COUNT: begin
                        w_refresh = 1'b1;
                        n_count   = {i_evt.hi, i_evt.lo};
                    end
                    default: begin
                        w_err = fcr_pkg::ERR_ORDER;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_status.frame_done      = i_evt.done;
        o_status.error_code      = w_err;
        o_status.main_power      = n_main;
        o_status.app_start       = n_app;
        o_status.power_on        = n_pwr;
        o_status.stop_request    = w_stop;
        o_status.clear_display   = w_clear;
        o_status.menu_init       = w_menu;
        o_status.refresh_request = w_refresh;
        o_status.pressure        = n_press;
        o_status.frequency       = n_freq;
        o_status.shock_count     = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main  <= 1'b0;
            r_app   <= 1'b0;
            r_pwr   <= 1'b0;
            r_press <= fcr_pkg::PRESS_RST;
            r_freq  <= 8'd0;
            r_count <= 16'd0;
        end else if (i_fire) begin
            r_main  <= n_main;
            r_app   <= n_app;
            r_pwr   <= n_pwr;
            r_press <= n_press;
            r_freq  <= n_freq;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/framed_command_receiver.sv -----
// Channel  Direction  Handshake              Payload
// in       slave      i_in_valid/o_in_stall   i_rx_byte
// out      master     o_out_valid/i_out_stall o_frame_done .. o_shock_count
// cfg      slave      i_cfg_we                i_cfg_wdata (idle pressure)
//
// One byte per cycle sustained while i_out_stall is low; a byte is held in the
// input register, then its result in the result register, where it is presented.
// Every accepted byte yields exactly one result transaction.
// Reset is synchronous on i_rst_n; state and levels return to their defaults.
// o_in_stall rises only while the input register holds a byte that cannot
// move because the result register is full and stalled.
module framed_command_receiver #(
    parameter int MAX_FRAME_LEN = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_done,
    output logic [1:0]  o_error_code,
    output logic        o_main_power,
    output logic        o_app_start,
    output logic        o_power_on,
    output logic        o_stop_request,
    output logic        o_clear_display,
    output logic        o_menu_init,
    output logic        o_refresh_request,
    output logic [7:0]  o_pressure,
    output logic [7:0]  o_frequency,
    output logic [15:0] o_shock_count
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    fcr_pkg::t_status    r_out;
    logic [7:0]          r_idle_press;
    logic                w_out_free;
    logic                w_fire;
    logic                w_in_take;
    fcr_pkg::t_frame_evt w_evt;
    fcr_pkg::t_status    w_status;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !w_out_free;

    fcr_parser #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .o_evt   (w_evt)
    );

    fcr_decoder u_decoder (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_evt           (w_evt),
        .i_idle_pressure (r_idle_press),
        .o_status        (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idle_press <= fcr_pkg::PRESS_RST;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_idle_press <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_fire) begin
            r_out <= w_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_done      = r_out.frame_done;
    assign o_error_code      = r_out.error_code;
    assign o_main_power      = r_out.main_power;
    assign o_app_start       = r_out.app_start;
    assign o_power_on        = r_out.power_on;
    assign o_stop_request    = r_out.stop_request;
    assign o_clear_display   = r_out.clear_display;
    assign o_menu_init       = r_out.menu_init;
    assign o_refresh_request = r_out.refresh_request;
    assign o_pressure        = r_out.pressure;
    assign o_frequency       = r_out.frequency;
    assign o_shock_count     = r_out.shock_count;

    a_err_needs_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.frame_done |-> r_out.error_code == fcr_pkg::ERR_NONE)
        else $error("error code without a completed frame");

    a_pulse_needs_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.stop_request || r_out.clear_display || r_out.menu_init
            || r_out.refresh_request)
        |-> r_out.frame_done && r_out.error_code == fcr_pkg::ERR_NONE)
        else $error("pulse raised outside a decoded frame");

    a_held_byte_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_free |=> r_in_valid && $stable(r_in_byte))
        else $error("blocked byte lost from the input register");

    a_fire_fills_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed byte produced no result");

endmodule

// ----- tb/framed_command_receiver_tb.sv -----
`timescale 1ns / 1ps

module framed_command_receiver_tb;

    localparam int MAX_LEN     = 128;
    localparam int HOLD_CYCLES = 120;
    localparam int N_PHASES    = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        recv_stall = 1'b0;
    logic        long_hold = 1'b0;
    logic        out_stall;

    logic        in_stall;
    logic        out_valid;
    logic        frame_done;
    logic [1:0]  error_code;
    logic        main_power;
    logic        app_start;
    logic        power_on;
    logic        stop_request;
    logic        clear_display;
    logic        menu_init;
    logic        refresh_request;
    logic [7:0]  pressure;
    logic [7:0]  frequency;
    logic [15:0] shock_count;

    assign out_stall = recv_stall | long_hold;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    framed_command_receiver #(
        .MAX_FRAME_LEN(MAX_LEN)
    ) u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_frame_done     (frame_done),
        .o_error_code     (error_code),
        .o_main_power     (main_power),
        .o_app_start      (app_start),
        .o_power_on       (power_on),
        .o_stop_request   (stop_request),
        .o_clear_display  (clear_display),
        .o_menu_init      (menu_init),
        .o_refresh_request(refresh_request),
        .o_pressure       (pressure),
        .o_frequency      (frequency),
        .o_shock_count    (shock_count)
    );

    // receiver-side model of the frame parser and the order decoder
    fcr_pkg::t_phase  rx_phase;
    logic [7:0]       frame_len;
    logic [7:0]       body_cnt;
    logic [7:0]       head_bytes [fcr_pkg::HEAD_KEEP];
    logic             main_power_lvl;
    logic             app_start_lvl;
    logic             handset_lvl;
    logic [7:0]       pressure_val;
    logic [7:0]       frequency_val;
    logic [15:0]      shock_cnt_val;
    logic [7:0]       idle_pressure;

    logic [7:0]       rx_byte_q [$];
    fcr_pkg::t_status status_q [$];

    logic        quiet_send = 1'b0;
    logic        quiet_recv = 1'b0;
    logic        hold_arm = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_wait = 0;
    int unsigned bytes_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned frames_seen = 0;
    int unsigned bad_cmd_seen = 0;
    int unsigned bad_order_seen = 0;
    int unsigned in_stall_cycles = 0;
    int unsigned mismatch_count = 0;

    function automatic void reset_model();
        rx_phase       = fcr_pkg::PH_SYNC0;
        frame_len      = 8'd0;
        body_cnt       = 8'd0;
        for (int i = 0; i < fcr_pkg::HEAD_KEEP; i++) head_bytes[i] = 8'h00;
        main_power_lvl = 1'b0;
        app_start_lvl  = 1'b0;
        handset_lvl    = 1'b0;
        pressure_val   = fcr_pkg::PRESS_RST;
        frequency_val  = 8'h00;
        shock_cnt_val  = 16'h0000;
        idle_pressure  = fcr_pkg::PRESS_RST;
    endfunction

    function automatic fcr_pkg::t_status predict_status(input logic [7:0] b);
        fcr_pkg::t_status st;
        logic [7:0]       code;
        logic [7:0]       hi;
        logic [7:0]       lo;
        st = '0;
        case (rx_phase)
            fcr_pkg::PH_SYNC0: begin
                rx_phase = (b == fcr_pkg::HDR_BYTE0) ? fcr_pkg::PH_SYNC1 : fcr_pkg::PH_SYNC0;
            end
            fcr_pkg::PH_SYNC1: begin
                rx_phase = (b == fcr_pkg::HDR_BYTE1) ? fcr_pkg::PH_LEN : fcr_pkg::PH_SYNC0;
            end
            fcr_pkg::PH_LEN: begin
                frame_len = (b > MAX_LEN) ? 8'(MAX_LEN) : b;
                body_cnt  = 8'd0;
                rx_phase  = (frame_len == 8'd0) ? fcr_pkg::PH_SYNC0 : fcr_pkg::PH_BODY;
            end
            default: begin
                if (body_cnt < fcr_pkg::HEAD_LIMIT) head_bytes[body_cnt[2:0]] = b;
                if (body_cnt != 8'hFF) body_cnt++;
                if (body_cnt >= frame_len) begin
                    st.frame_done = 1'b1;
                    if (frame_len >= 8'd2) begin
                        code = head_bytes[1];
                        hi   = head_bytes[3];
                        lo   = head_bytes[4];
                        if (head_bytes[0] != fcr_pkg::CMD_TYPE) begin
                            st.error_code = fcr_pkg::ERR_CMD;
                        end else begin
                            case (code)
                                fcr_pkg::ORD_MAIN_POWER: begin
                                    if (lo == fcr_pkg::ARG_ONE) begin
                                        main_power_lvl = 1'b1;
                                    end else begin
                                        main_power_lvl   = 1'b0;
                                        pressure_val     = idle_pressure;
                                        frequency_val    = 8'h00;
                                        shock_cnt_val    = 16'h0000;
                                        handset_lvl      = 1'b0;
                                        st.stop_request  = 1'b1;
                                        st.clear_display = 1'b1;
                                    end
                                end
                                fcr_pkg::ORD_APP_START: begin
                                    if (lo == fcr_pkg::ARG_ONE) begin
                                        app_start_lvl = 1'b1;
                                    end else begin
                                        app_start_lvl      = 1'b0;
                                        st.refresh_request = 1'b1;
                                        st.stop_request    = 1'b1;
                                    end
                                end
                                fcr_pkg::ORD_HANDSET: begin
                                    if (lo == fcr_pkg::ARG_ZERO) begin
                                        handset_lvl      = 1'b0;
                                        st.stop_request  = 1'b1;
                                        st.clear_display = 1'b1;
                                    end else begin
                                        handset_lvl        = 1'b1;
                                        st.refresh_request = 1'b1;
                                        st.menu_init       = 1'b1;
                                    end
                                end
                                fcr_pkg::ORD_FREQUENCY: begin
                                    st.refresh_request = 1'b1;
                                    frequency_val      = lo;
                                end
                                fcr_pkg::ORD_PRESSURE: begin
                                    st.refresh_request = 1'b1;
                                    pressure_val       = lo;
                                end
                                fcr_pkg::ORD_COUNT: begin
                                    st.refresh_request = 1'b1;
                                    shock_cnt_val      = {hi, lo};
                                end
                                default: begin
                                    st.error_code = fcr_pkg::ERR_ORDER;
                                end
                            endcase
                        end
                    end
                    body_cnt = 8'd0;
                    rx_phase = fcr_pkg::PH_SYNC0;
                end
            end
        endcase
        st.main_power  = main_power_lvl;
        st.app_start   = app_start_lvl;
        st.power_on    = handset_lvl;
        st.pressure    = pressure_val;
        st.frequency   = frequency_val;
        st.shock_count = shock_cnt_val;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("ERROR t=%0t result %0d: %s got 0x%0h, want 0x%0h",
                     $realtime, results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic check_status(input fcr_pkg::t_status got, input fcr_pkg::t_status want);
        check_field("frame_done",      16'(got.frame_done),      16'(want.frame_done));
        check_field("error_code",      16'(got.error_code),      16'(want.error_code));
        check_field("main_power",      16'(got.main_power),      16'(want.main_power));
        check_field("app_start",       16'(got.app_start),       16'(want.app_start));
        check_field("power_on",        16'(got.power_on),        16'(want.power_on));
        check_field("stop_request",    16'(got.stop_request),    16'(want.stop_request));
        check_field("clear_display",   16'(got.clear_display),   16'(want.clear_display));
        check_field("menu_init",       16'(got.menu_init),       16'(want.menu_init));
        check_field("refresh_request", 16'(got.refresh_request), 16'(want.refresh_request));
        check_field("pressure",        16'(got.pressure),        16'(want.pressure));
        check_field("frequency",       16'(got.frequency),       16'(want.frequency));
        check_field("shock_count",     got.shock_count,          want.shock_count);
    endtask

    function automatic int unsigned draw_wait(input logic quiet);
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // byte source
    always @(posedge clk) begin
        logic take;
        take = in_valid && !in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_stall) in_stall_cycles++;
            if (take) begin
                status_q.push_back(predict_status(rx_byte));
                bytes_accepted++;
            end
            if (!in_valid || take) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (rx_byte_q.size() != 0) begin
                    rx_byte  <= rx_byte_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= draw_wait(quiet_send);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge clk) begin
        fcr_pkg::t_status got;
        int unsigned n;
        if (!rst_n) begin
            recv_stall <= 1'b0;
            recv_wait  <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                got = {frame_done, error_code, main_power, app_start, power_on,
                       stop_request, clear_display, menu_init, refresh_request,
                       pressure, frequency, shock_count};
                if (status_q.size() == 0) begin
                    report_mismatch("unexpected result", 16'(got.frame_done), 16'h0);
                end else begin
                    check_status(got, status_q.pop_front());
                end
                results_seen++;
                if (got.frame_done) frames_seen++;
                if (got.error_code == fcr_pkg::ERR_CMD) bad_cmd_seen++;
                if (got.error_code == fcr_pkg::ERR_ORDER) bad_order_seen++;
                n = draw_wait(quiet_recv);
                recv_wait  <= n;
                recv_stall <= (n != 0);
            end else if (recv_wait != 0) begin
                recv_wait  <= recv_wait - 1;
                recv_stall <= (recv_wait > 1);
            end
        end
    end

    // long receiver hold-off so the input side backs up
    initial begin
        while (!hold_arm) @(negedge clk);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic queue_frame(input logic [7:0] len_field, input logic [7:0] cmd,
                               input logic [7:0] code, input logic [7:0] hi,
                               input logic [7:0] lo);
        int n;
        n = (len_field > MAX_LEN) ? MAX_LEN : len_field;
        rx_byte_q.push_back(fcr_pkg::HDR_BYTE0);
        rx_byte_q.push_back(fcr_pkg::HDR_BYTE1);
        rx_byte_q.push_back(len_field);
        for (int i = 0; i < n; i++) begin
            case (i)
                0:       rx_byte_q.push_back(cmd);
                1:       rx_byte_q.push_back(code);
                3:       rx_byte_q.push_back(hi);
                4:       rx_byte_q.push_back(lo);
                default: rx_byte_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic queue_random_traffic(input int n_bytes);
        logic [7:0] orders [6];
        logic [7:0] len_field;
        logic [7:0] cmd;
        logic [7:0] code;
        logic [7:0] lo;
        logic [7:0] b;
        int         kind;
        int         sel;
        orders = '{fcr_pkg::ORD_MAIN_POWER, fcr_pkg::ORD_APP_START, fcr_pkg::ORD_HANDSET,
                   fcr_pkg::ORD_FREQUENCY, fcr_pkg::ORD_PRESSURE, fcr_pkg::ORD_COUNT};
        while (rx_byte_q.size() < n_bytes) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                repeat ($urandom_range(1, 4)) rx_byte_q.push_back(8'($urandom_range(0, 255)));
            end else if (kind == 1) begin
                b = 8'($urandom_range(0, 255));
                rx_byte_q.push_back(fcr_pkg::HDR_BYTE0);
                rx_byte_q.push_back((b == fcr_pkg::HDR_BYTE1) ? 8'h00 : b);
            end else begin
                sel = $urandom_range(0, 19);
                if (sel == 0)      len_field = 8'd0;
                else if (sel == 1) len_field = 8'd1;
                else if (sel < 5)  len_field = 8'($urandom_range(2, 4));
                else               len_field = 8'($urandom_range(5, 9));
                cmd  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : fcr_pkg::CMD_TYPE;
                sel  = $urandom_range(0, 6);
                code = (sel == 6) ? 8'($urandom_range(0, 255)) : orders[sel];
                sel  = $urandom_range(0, 2);
                lo   = (sel == 0) ? fcr_pkg::ARG_ZERO : (sel == 1) ? fcr_pkg::ARG_ONE
                                                      : 8'($urandom_range(0, 255));
                queue_frame(len_field, cmd, code, 8'($urandom_range(0, 255)), lo);
            end
        end
    endtask

    task automatic write_idle_pressure(input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        idle_pressure = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (rx_byte_q.size() != 0 || in_valid || status_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        logic [7:0] press_values [N_PHASES];
        reset_model();
        press_values = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h01,
                         8'($urandom_range(0, 255)), 8'h80};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames, idle pressure at its reset value
        quiet_send = 1'b1;
        quiet_recv = 1'b1;
        rx_byte_q.push_back(fcr_pkg::HDR_BYTE0);
        rx_byte_q.push_back(fcr_pkg::HDR_BYTE0);
        rx_byte_q.push_back(fcr_pkg::HDR_BYTE1);
        rx_byte_q.push_back(fcr_pkg::HDR_BYTE0);
        rx_byte_q.push_back(fcr_pkg::HDR_BYTE1);
        rx_byte_q.push_back(8'h00);
        queue_frame(8'd1, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_PRESSURE, 8'h00, 8'h00);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_COUNT, 8'hFF, 8'hFF);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_FREQUENCY, 8'h00, 8'hFF);
        queue_frame(8'd2, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_PRESSURE, 8'h00, 8'h00);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_MAIN_POWER, 8'h00, fcr_pkg::ARG_ONE);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_APP_START, 8'h00, fcr_pkg::ARG_ONE);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_HANDSET, 8'h00, fcr_pkg::ARG_ONE);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_HANDSET, 8'h00, fcr_pkg::ARG_ZERO);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_APP_START, 8'h00, fcr_pkg::ARG_ZERO);
        queue_frame(8'd5, 8'h00, fcr_pkg::ORD_PRESSURE, 8'h00, 8'h33);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, 8'hFF, 8'h00, 8'h33);
        queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_MAIN_POWER, 8'h00, fcr_pkg::ARG_ZERO);
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            write_idle_pressure(press_values[p]);
            quiet_send = (p % 3 == 1);
            quiet_recv = (p % 4 == 3);
            if (p == 1)
                queue_frame(8'($urandom_range(MAX_LEN + 1, 255)), fcr_pkg::CMD_TYPE,
                            fcr_pkg::ORD_COUNT, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
            queue_random_traffic(rx_byte_q.size() + 25);
            queue_frame(8'd5, fcr_pkg::CMD_TYPE, fcr_pkg::ORD_MAIN_POWER, 8'h00,
                        fcr_pkg::ARG_ZERO);
            if (p == 2) begin
                quiet_send = 1'b1;
                hold_arm   = 1'b1;
            end
            drain();
        end

        repeat (8) @(negedge clk);
        if (status_q.size() != 0)
            report_mismatch("results never arrived", 16'(status_q.size()), 16'h0);
        $display("Run covered %0d bytes, %0d completed frames, %0d bad command, %0d bad order",
                 bytes_accepted, frames_seen, bad_cmd_seen, bad_order_seen);
        $display("Input side was held back for %0d cycles; %0d idle pressure settings",
                 in_stall_cycles, N_PHASES + 1);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fcr_pkg.sv
rtl/fcr_parser.sv
rtl/fcr_decoder.sv
rtl/framed_command_receiver.sv
tb/framed_command_receiver_tb.sv
